// ===== sv/random_waypoint_mobility_step_macros.svh =====
// Assertion macros used by the RTL
`ifndef RANDOM_WAYPOINT_MOBILITY_STEP_MACROS_SVH
`define RANDOM_WAYPOINT_MOBILITY_STEP_MACROS_SVH

// cond must never hold while out of reset
`define RWM_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define RWM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/rwm_pkg.sv =====
`timescale 1ns / 1ps
package rwm_pkg;

    localparam int POS_W    = 32;
    localparam int DELTA_W  = 20;
    localparam int SPEED_W  = 26;
    localparam int PAUSE_W  = 32;
    localparam int RAD_W    = 16;
    localparam int SUM_W    = 65;
    localparam int ROOT_W   = 33;
    localparam int FRAC_W   = 16;
    localparam int UNIT_W   = 17;
    localparam int STEP_W   = 30;
    localparam int PROD_W   = 64;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd6554;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP,
        ST_MX,
        ST_MY,
        ST_SUM,
        ST_ROOT,
        ST_DIVX,
        ST_MULX,
        ST_MVX,
        ST_DIVY,
        ST_MULY,
        ST_MVY,
        ST_DONE
    } state_t;

endpackage

// ===== sv/rwm_in_if.sv =====
`timescale 1ns / 1ps
interface rwm_in_if;
    logic               valid;
    logic               ready;
    logic [19:0]        delta_t;
    logic signed [31:0] new_dest_x;
    logic signed [31:0] new_dest_y;
    logic [25:0]        new_speed;
    logic [31:0]        new_pause;

    modport source (output valid, delta_t, new_dest_x, new_dest_y, new_speed, new_pause,
                    input ready);
    modport sink (input valid, delta_t, new_dest_x, new_dest_y, new_speed, new_pause,
                  output ready);
endinterface

// ===== sv/rwm_out_if.sv =====
`timescale 1ns / 1ps
interface rwm_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               is_moving;
    logic               took_pause_draw;
    logic               took_leg_draw;

    modport source (output valid, pos_x, pos_y, is_moving, took_pause_draw, took_leg_draw,
                    input ready);
    modport sink (input valid, pos_x, pos_y, is_moving, took_pause_draw, took_leg_draw,
                  output ready);
endinterface

// ===== sv/rwm_isqrt.sv =====
`timescale 1ns / 1ps
module rwm_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rwm_pkg::SUM_W-1:0]  radicand,
    output logic                       done,
    output logic [rwm_pkg::ROOT_W-1:0] root
);
    import rwm_pkg::*;

    localparam int RAD2_W = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;
    localparam int CNT_W  = $clog2(ROOT_W);

    logic [RAD2_W-1:0] rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    always_comb
    begin
        rem_sh    = {rem_reg[REM_W-3:0], rad_reg[RAD2_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        ge        = (rem_sh >= trial);
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = {{(RAD2_W - SUM_W){1'b0}}, radicand};
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W - 1);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rad_next  = {rad_reg[RAD2_W-3:0], 2'b00};
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[ROOT_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// ===== sv/rwm_div.sv =====
`timescale 1ns / 1ps
module rwm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rwm_pkg::POS_W-1:0]  num,
    input  logic [rwm_pkg::ROOT_W-1:0] den,
    output logic                       done,
    output logic [rwm_pkg::UNIT_W-1:0] quo
);
    import rwm_pkg::*;

    localparam int REM_W = POS_W + FRAC_W;
    localparam int DV_W  = ROOT_W + FRAC_W;
    localparam int CNT_W = $clog2(UNIT_W);

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DV_W-1:0]   dv_reg, dv_next;
    logic [UNIT_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic              ge;

    always_comb
    begin
        ge        = ({{(DV_W - REM_W){1'b0}}, rem_reg} >= dv_reg);
        rem_next  = rem_reg;
        dv_next   = dv_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = {num, {FRAC_W{1'b0}}};
            dv_next  = {den, {FRAC_W{1'b0}}};
            q_next   = '0;
            cnt_next = CNT_W'(UNIT_W - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dv_reg[REM_W-1:0];
            end
            q_next   = {q_reg[UNIT_W-2:0], ge};
            dv_next  = dv_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dv_reg  <= dv_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule

// ===== sv/random_waypoint_mobility_step.sv =====
// Random waypoint mobility, one node, Q16.16. Each tick beat on tick yields one result beat.
// A paused tick goes to DONE. A moving tick runs a bit-serial square root of 33 steps on the
// distance; if the step is shorter, a restoring divider of 17 steps runs twice (unit x, then
// y) and the root reruns after the move. One shared 32x32 multiplier forms speed times
// delta, the squares and the move lengths. tick.ready is high only between ticks; a finished
// result may wait in the output register while the next tick is taken. The user must write
// arrival_radius via cfg_wr_en/cfg_wr_data between ticks; the block does not enforce it.
`timescale 1ns / 1ps
`include "random_waypoint_mobility_step_macros.svh"
module random_waypoint_mobility_step (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [rwm_pkg::RAD_W-1:0] cfg_wr_data,
    rwm_in_if.sink                    tick,
    rwm_out_if.source                 result
);
    import rwm_pkg::*;

    state_t state_reg, state_next;

    logic                      phase_reg, phase_next;
    logic                      moving_reg, moving_next;
    logic signed [PAUSE_W:0]   pause_reg, pause_next;
    logic signed [POS_W-1:0]   px_reg, px_next, py_reg, py_next;
    logic signed [POS_W-1:0]   tx_reg, tx_next, ty_reg, ty_next;
    logic [SPEED_W-1:0]        speed_reg, speed_next;
    logic [RAD_W-1:0]          radius_reg, radius_next;
    logic [DELTA_W-1:0]        delta_reg, delta_next;
    logic [PAUSE_W-1:0]        pin_reg, pin_next;
    logic [POS_W-1:0]          ax_reg, ax_next, ay_reg, ay_next;
    logic                      negx_reg, negx_next, negy_reg, negy_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [ROOT_W-1:0]         dist_reg, dist_next;
    logic [UNIT_W-1:0]         unit_reg, unit_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic                      tp_reg, tp_next, tl_reg, tl_next;

    logic                      ov_reg, ov_next;
    logic signed [POS_W-1:0]   opx_reg, opx_next, opy_reg, opy_next;
    logic                      om_reg, om_next, otp_reg, otp_next, otl_reg, otl_next;

    logic [POS_W-1:0]          mul_a, mul_b;
    logic signed [POS_W:0]     dx, dy;
    logic signed [PAUSE_W:0]   pause_dec;
    logic                      sq_start, sq_done;
    logic [SUM_W-1:0]          sq_rad;
    logic [ROOT_W-1:0]         sq_root;
    logic                      dv_start, dv_done;
    logic [POS_W-1:0]          dv_num;
    logic [ROOT_W-1:0]         dv_den;
    logic [UNIT_W-1:0]         dv_quo;
    logic [POS_W-2:0]          mv;
    logic                      neg_sel;
    logic signed [POS_W-1:0]   pos_sel;
    logic signed [POS_W+1:0]   pos_sum;
    logic signed [POS_W-1:0]   pos_sat;
    logic                      arrive;
    logic                      load_out;

    rwm_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .done     (sq_done),
        .root     (sq_root)
    );

    rwm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (dv_num),
        .den   (dv_den),
        .done  (dv_done),
        .quo   (dv_quo)
    );

    always_comb
    begin
        dx        = {tx_reg[POS_W-1], tx_reg} - {px_reg[POS_W-1], px_reg};
        dy        = {ty_reg[POS_W-1], ty_reg} - {py_reg[POS_W-1], py_reg};
        pause_dec = pause_reg - $signed({{(PAUSE_W + 1 - DELTA_W){1'b0}}, tick.delta_t});
        mv        = prod_reg[FRAC_W +: POS_W-1];
        neg_sel   = (state_reg == ST_MVX) ? negx_reg : negy_reg;
        pos_sel   = (state_reg == ST_MVX) ? px_reg : py_reg;
        if (neg_sel)
        begin
            pos_sum = {{2{pos_sel[POS_W-1]}}, pos_sel} - $signed({3'b000, mv});
        end
        else
        begin
            pos_sum = {{2{pos_sel[POS_W-1]}}, pos_sel} + $signed({3'b000, mv});
        end
        if (pos_sum[POS_W+1:POS_W-1] == 3'b000 || pos_sum[POS_W+1:POS_W-1] == 3'b111)
        begin
            pos_sat = pos_sum[POS_W-1:0];
        end
        else if (pos_sum[POS_W+1])
        begin
            pos_sat = {1'b1, {(POS_W-1){1'b0}}};
        end
        else
        begin
            pos_sat = {1'b0, {(POS_W-1){1'b1}}};
        end

        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_STEP:
            begin
                mul_a = {{(POS_W - SPEED_W){1'b0}}, speed_reg};
                mul_b = {{(POS_W - DELTA_W){1'b0}}, delta_reg};
            end
            ST_MX:
            begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            ST_MY:
            begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            ST_MULX, ST_MULY:
            begin
                mul_a = {{(POS_W - UNIT_W){1'b0}}, unit_reg};
                mul_b = {{(POS_W - STEP_W){1'b0}}, step_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;

        sq_start = (state_reg == ST_SUM);
        sq_rad   = sum_reg + {1'b0, prod_reg};
        dv_start = 1'b0;
        dv_num   = (state_reg == ST_ROOT) ? ax_reg : ay_reg;
        dv_den   = (state_reg == ST_ROOT) ? sq_root : dist_reg;
        arrive   = 1'b0;
        load_out = 1'b0;

        state_next  = state_reg;
        phase_next  = phase_reg;
        moving_next = moving_reg;
        pause_next  = pause_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        tx_next     = tx_reg;
        ty_next     = ty_reg;
        speed_next  = speed_reg;
        delta_next  = delta_reg;
        pin_next    = pin_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        negx_next   = negx_reg;
        negy_next   = negy_reg;
        step_next   = step_reg;
        sum_next    = sum_reg;
        dist_next   = dist_reg;
        unit_next   = unit_reg;
        tp_next     = tp_reg;
        tl_next     = tl_reg;
        radius_next = cfg_wr_en ? cfg_wr_data : radius_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick.valid)
                begin
                    delta_next = tick.delta_t;
                    pin_next   = tick.new_pause;
                    phase_next = 1'b0;
                    tp_next    = 1'b0;
                    tl_next    = 1'b0;
                    if (moving_reg)
                    begin
                        state_next = ST_STEP;
                    end
                    else
                    begin
                        pause_next = pause_dec;
                        if (pause_dec[PAUSE_W] || pause_dec == '0)
                        begin
                            moving_next = 1'b1;
                            tx_next     = tick.new_dest_x;
                            ty_next     = tick.new_dest_y;
                            speed_next  = tick.new_speed;
                            tl_next     = 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_STEP:
            begin
                negx_next  = dx[POS_W];
                negy_next  = dy[POS_W];
                ax_next    = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
                ay_next    = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
                state_next = ST_MX;
            end
            ST_MX:
            begin
                if (!phase_reg)
                begin
                    step_next = prod_reg[FRAC_W +: STEP_W];
                end
                state_next = ST_MY;
            end
            ST_MY:
            begin
                sum_next   = {1'b0, prod_reg};
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (sq_done)
                begin
                    if (!phase_reg)
                    begin
                        dist_next = sq_root;
                        if ({3'b000, step_reg} >= sq_root)
                        begin
                            px_next    = tx_reg;
                            py_next    = ty_reg;
                            arrive     = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            dv_start   = 1'b1;
                            state_next = ST_DIVX;
                        end
                    end
                    else
                    begin
                        arrive     = (sq_root < {{(ROOT_W - RAD_W){1'b0}}, radius_reg});
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIVX:
            begin
                if (dv_done)
                begin
                    unit_next  = dv_quo;
                    state_next = ST_MULX;
                end
            end
            ST_MULX:
            begin
                state_next = ST_MVX;
            end
            ST_MVX:
            begin
                px_next    = pos_sat;
                dv_start   = 1'b1;
                state_next = ST_DIVY;
            end
            ST_DIVY:
            begin
                if (dv_done)
                begin
                    unit_next  = dv_quo;
                    state_next = ST_MULY;
                end
            end
            ST_MULY:
            begin
                state_next = ST_MVY;
            end
            ST_MVY:
            begin
                py_next    = pos_sat;
                phase_next = 1'b1;
                state_next = ST_STEP;
            end
            ST_DONE:
            begin
                if (!ov_reg || result.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (arrive)
        begin
            moving_next = 1'b0;
            pause_next  = $signed({1'b0, pin_reg});
            tp_next     = 1'b1;
        end

        ov_next  = load_out ? 1'b1 : (result.ready ? 1'b0 : ov_reg);
        opx_next = load_out ? px_reg : opx_reg;
        opy_next = load_out ? py_reg : opy_reg;
        om_next  = load_out ? moving_reg : om_reg;
        otp_next = load_out ? tp_reg : otp_reg;
        otl_next = load_out ? tl_reg : otl_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= 1'b0;
            moving_reg <= 1'b0;
            pause_reg  <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            tx_reg     <= '0;
            ty_reg     <= '0;
            speed_reg  <= '0;
            radius_reg <= RADIUS_RESET;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            moving_reg <= moving_next;
            pause_reg  <= pause_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
            tx_reg     <= tx_next;
            ty_reg     <= ty_next;
            speed_reg  <= speed_next;
            radius_reg <= radius_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg <= delta_next;
        pin_reg   <= pin_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        negx_reg  <= negx_next;
        negy_reg  <= negy_next;
        step_reg  <= step_next;
        sum_reg   <= sum_next;
        dist_reg  <= dist_next;
        unit_reg  <= unit_next;
        prod_reg  <= prod_next;
        tp_reg    <= tp_next;
        tl_reg    <= tl_next;
        opx_reg   <= opx_next;
        opy_reg   <= opy_next;
        om_reg    <= om_next;
        otp_reg   <= otp_next;
        otl_reg   <= otl_next;
    end

    assign tick.ready             = (state_reg == ST_IDLE);
    assign result.valid           = ov_reg;
    assign result.pos_x           = opx_reg;
    assign result.pos_y           = opy_reg;
    assign result.is_moving       = om_reg;
    assign result.took_pause_draw = otp_reg;
    assign result.took_leg_draw   = otl_reg;

    `RWM_ASSERT_IMPLY(a_load_from_done, $rose(ov_reg), $past(state_reg == ST_DONE), "result without finished tick")
    `RWM_ASSERT_NEVER(a_one_draw, ov_reg && otp_reg && otl_reg, "both draws taken in one tick")
    `RWM_ASSERT_IMPLY(a_leg_moves, ov_reg && otl_reg, om_reg, "leg draw but not moving")
    `RWM_ASSERT_IMPLY(a_pause_stops, ov_reg && otp_reg, !om_reg, "pause draw but still moving")
endmodule

// ===== test/random_waypoint_mobility_step_test.sv =====
`timescale 1ns / 1ps
module random_waypoint_mobility_step_test;
    import rwm_pkg::*;

    typedef struct {
        logic [19:0]        delta_t;
        logic signed [31:0] dest_x;
        logic signed [31:0] dest_y;
        logic [25:0]        speed;
        logic [31:0]        pause;
    } tick_t;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               is_moving;
        logic               took_pause_draw;
        logic               took_leg_draw;
    } position_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [RAD_W-1:0] cfg_wr_data;

    rwm_in_if  tick_bus ();
    rwm_out_if result_bus ();

    random_waypoint_mobility_step i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tick        (tick_bus.sink),
        .result      (result_bus.source)
    );

    // node model state
    logic signed [63:0] node_x, node_y, goal_x, goal_y, pause_rem;
    logic [25:0]        node_speed;
    logic               node_moving;
    logic [15:0]        radius;

    tick_t     pending_ticks[$];
    position_t expected_positions[$];
    int        failures;
    int        cycle_count;
    bit        sender_idles;
    bit        receiver_idles;
    bit        hold_sender;

    function automatic logic [32:0] isqrt(logic signed [63:0] dx, logic signed [63:0] dy);
        logic [32:0]  ax, ay, r, c;
        logic [65:0]  sum;
        ax = 33'(dx < 0 ? -dx : dx);
        ay = 33'(dy < 0 ? -dy : dy);
        sum = {33'd0, ax} * ax + {33'd0, ay} * ay;
        r = '0;
        for (int b = 32; b >= 0; b--)
        begin
            c = r | (33'd1 << b);
            if ({33'd0, c} * c <= sum)
                r = c;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] advance_axis(logic signed [63:0] p,
            logic signed [63:0] d, logic [32:0] span, logic [63:0] stp);
        logic [63:0] ad, unit, mv;
        logic signed [63:0] v;
        ad = d < 0 ? -d : d;
        unit = (ad << 16) / span;
        mv = (unit * stp) >> 16;
        v = d < 0 ? p - $signed(mv) : p + $signed(mv);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v;
    endfunction

    function automatic position_t predict_tick(tick_t t);
        position_t r;
        logic [32:0] span;
        logic [63:0] stp;
        logic arrived;
        r.took_pause_draw = 0;
        r.took_leg_draw = 0;
        if (node_moving)
        begin
            span = isqrt(goal_x - node_x, goal_y - node_y);
            stp = ({38'd0, node_speed} * t.delta_t) >> 16;
            if (stp >= span)
            begin
                node_x = goal_x;
                node_y = goal_y;
                arrived = 1;
            end
            else
            begin
                node_x = advance_axis(node_x, goal_x - node_x, span, stp);
                node_y = advance_axis(node_y, goal_y - node_y, span, stp);
                arrived = isqrt(goal_x - node_x, goal_y - node_y) < radius;
            end
            if (arrived)
            begin
                node_moving = 0;
                pause_rem = {32'd0, t.pause};
                r.took_pause_draw = 1;
            end
        end
        else
        begin
            pause_rem = pause_rem - t.delta_t;
            if (pause_rem <= 0)
            begin
                node_moving = 1;
                goal_x = t.dest_x;
                goal_y = t.dest_y;
                node_speed = t.speed;
                r.took_leg_draw = 1;
            end
        end
        r.pos_x = node_x[31:0];
        r.pos_y = node_y[31:0];
        r.is_moving = node_moving;
        return r;
    endfunction

    function automatic tick_t rand_tick(int mode);
        tick_t t;
        t.dest_x = $urandom;
        t.dest_y = $urandom;
        t.speed = 26'($urandom);
        t.pause = $urandom;
        t.delta_t = 20'($urandom);
        case (mode)
            0:
            begin
                t.dest_x = $signed($urandom_range(2000000)) - 1000000;
                t.dest_y = $signed($urandom_range(2000000)) - 1000000;
                t.speed = 26'($urandom_range(1 << 20));
                t.pause = $urandom_range(1 << 18);
                t.delta_t = 20'($urandom_range(1 << 17));
            end
            1:
                t.pause = $urandom_range(3);
            default: ;
        endcase
        return t;
    endfunction

    task automatic add_tick(logic [19:0] dt, logic [31:0] dx, logic [31:0] dy,
            logic [25:0] sp, logic [31:0] pz);
        tick_t t;
        t.delta_t = dt;
        t.dest_x = dx;
        t.dest_y = dy;
        t.speed = sp;
        t.pause = pz;
        pending_ticks = {pending_ticks, t};
    endtask

    task automatic drain_and_set_radius(logic [15:0] value);
        while (pending_ticks.size() != 0 || expected_positions.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        cfg_wr_en <= 1;
        cfg_wr_data <= value;
        radius = value;
        @(posedge clk);
        cfg_wr_en <= 0;
    endtask

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_bus.valid <= 0;
        end
        else
        begin
            if (tick_bus.valid && tick_bus.ready)
            begin
                position_t p;
                p = predict_tick(pending_ticks.pop_front());
                expected_positions = {expected_positions, p};
            end
            if (tick_bus.valid && !tick_bus.ready)
                ;
            else if (pending_ticks.size() != 0 && !hold_sender &&
                     !(sender_idles && $urandom_range(99) < 27))
            begin
                tick_bus.valid <= 1;
                tick_bus.delta_t <= pending_ticks[0].delta_t;
                tick_bus.new_dest_x <= pending_ticks[0].dest_x;
                tick_bus.new_dest_y <= pending_ticks[0].dest_y;
                tick_bus.new_speed <= pending_ticks[0].speed;
                tick_bus.new_pause <= pending_ticks[0].pause;
            end
            else
                tick_bus.valid <= 0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_positions.size() == 0)
                begin
                    $error("unexpected result beat");
                    failures++;
                end
                else
                begin
                    position_t e;
                    e = expected_positions.pop_front();
                    if (result_bus.pos_x !== e.pos_x)
                    begin
                        $error("pos_x exp %0d got %0d", e.pos_x, result_bus.pos_x);
                        failures++;
                    end
                    if (result_bus.pos_y !== e.pos_y)
                    begin
                        $error("pos_y exp %0d got %0d", e.pos_y, result_bus.pos_y);
                        failures++;
                    end
                    if (result_bus.is_moving !== e.is_moving)
                    begin
                        $error("is_moving exp %0b got %0b", e.is_moving,
                               result_bus.is_moving);
                        failures++;
                    end
                    if (result_bus.took_pause_draw !== e.took_pause_draw)
                    begin
                        $error("took_pause_draw exp %0b got %0b", e.took_pause_draw,
                               result_bus.took_pause_draw);
                        failures++;
                    end
                    if (result_bus.took_leg_draw !== e.took_leg_draw)
                    begin
                        $error("took_leg_draw exp %0b got %0b", e.took_leg_draw,
                               result_bus.took_leg_draw);
                        failures++;
                    end
                end
            end
            result_bus.ready <= !(receiver_idles && $urandom_range(99) < 27);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        failures = 0;
        cycle_count = 0;
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        tick_bus.valid = 0;
        tick_bus.delta_t = 0;
        tick_bus.new_dest_x = 0;
        tick_bus.new_dest_y = 0;
        tick_bus.new_speed = 0;
        tick_bus.new_pause = 0;
        result_bus.ready = 0;
        sender_idles = 0;
        receiver_idles = 0;
        hold_sender = 0;
        node_x = 0;
        node_y = 0;
        goal_x = 0;
        goal_y = 0;
        node_speed = 0;
        pause_rem = 0;
        node_moving = 0;
        radius = RADIUS_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1;

        // directed: resume after reset, extremes, zero length, exact arrival, saturation
        add_tick(20'd0, 32'h7fffffff, 32'h80000000, 26'h3ffffff, 32'hffffffff);
        add_tick(20'd1, 0, 0, 0, 32'h00010000);
        add_tick(20'hfffff, 0, 0, 0, 32'h0);
        add_tick(20'hfffff, 32'h80000000, 32'h7fffffff, 26'h3ffffff, 32'h0);
        add_tick(20'h10000, 0, 0, 0, 32'h10);
        add_tick(20'h10000, 0, 0, 0, 32'h10);
        add_tick(20'h0, 32'h00050000, 32'hfffb0000, 26'h10000, 32'hffffffff);
        add_tick(20'h0, 32'h00050000, 32'hfffb0000, 26'h10000, 32'h1);
        add_tick(20'h8000, 0, 0, 0, 32'h2);
        add_tick(20'h10000, 0, 0, 26'h3ffffff, 32'h0);
        add_tick(20'h30000, 0, 0, 0, 32'h0);
        add_tick(20'hfffff, 32'h7fffffff, 32'h7fffffff, 26'h3ffffff, 32'h0);
        for (int i = 0; i < 6; i++)
            add_tick(20'hfffff, 32'h7fffffff, 32'h7fffffff, 26'h3ffffff, 32'h0);
        drain_and_set_radius(16'hffff);
        for (int i = 0; i < 8; i++)
            pending_ticks = {pending_ticks, rand_tick(0)};
        drain_and_set_radius(16'h0);
        for (int i = 0; i < 8; i++)
            pending_ticks = {pending_ticks, rand_tick(0)};
        drain_and_set_radius(RADIUS_RESET);

        // long stretch without idling, then random idling
        for (int i = 0; i < 60; i++)
            pending_ticks = {pending_ticks, rand_tick(0)};
        while (pending_ticks.size() != 0)
            @(posedge clk);
        sender_idles = 1;
        receiver_idles = 1;
        for (int i = 0; i < 140; i++)
            pending_ticks = {pending_ticks,
                             rand_tick($urandom_range(9) < 7 ? 0 : $urandom_range(2))};
        while (pending_ticks.size() > 70)
            @(posedge clk);
        hold_sender = 1;
        while (expected_positions.size() != 0 || (tick_bus.valid === 1'b1))
            @(posedge clk);
        hold_sender = 0;
        drain_and_set_radius(16'($urandom_range(65535)));
        for (int i = 0; i < 160; i++)
            pending_ticks = {pending_ticks,
                             rand_tick($urandom_range(9) < 7 ? 0 : $urandom_range(2))};

        while (pending_ticks.size() != 0 || expected_positions.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
